### hw/rtl/debounced_bus_fault_protection_assert.svh
// Assertion macros for the bus fault protection block.
`ifndef DEBOUNCED_BUS_FAULT_PROTECTION_ASSERT_SVH
`define DEBOUNCED_BUS_FAULT_PROTECTION_ASSERT_SVH
`ifndef SYNTH
`define DBFP_ASSERT_SAME(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("same-cycle check failed");
`define DBFP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("next-cycle check failed");
`else
`define DBFP_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define DBFP_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

### hw/rtl/dbfp_pkg.sv
// Types and constants shared by the bus fault protection block.
package dbfp_pkg;

  localparam int HIT_COUNT_WIDTH = 8;
  localparam int SAMPLE_WIDTH    = 16;

  localparam int VOLT_LIMIT_W  = 16;
  localparam int CUR_LIMIT_W   = 15;
  localparam int TRIP_W        = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int FAULT_W       = 5;
  localparam int HIT_BITS      = 4;

  localparam int VOLT_CMP_W = (SAMPLE_WIDTH > VOLT_LIMIT_W) ? SAMPLE_WIDTH : VOLT_LIMIT_W;
  localparam int CUR_CMP_W  = (SAMPLE_WIDTH > CUR_LIMIT_W) ? SAMPLE_WIDTH : CUR_LIMIT_W;
  localparam int TRIP_CMP_W = (HIT_COUNT_WIDTH > TRIP_W) ? HIT_COUNT_WIDTH : TRIP_W;

  // fault bit positions
  localparam int BIT_UV   = 0;
  localparam int BIT_OV   = 1;
  localparam int BIT_OC   = 2;
  localparam int BIT_IMB  = 3;
  localparam int BIT_LOST = 4;

  localparam logic [VOLT_LIMIT_W-1:0] UV_LIMIT_RST  = 16'd10240;
  localparam logic [VOLT_LIMIT_W-1:0] OV_LIMIT_RST  = 16'd14848;
  localparam logic [VOLT_LIMIT_W-1:0] IMB_LIMIT_RST = 16'd2560;
  localparam logic [CUR_LIMIT_W-1:0]  OC_LIMIT_RST  = 15'd3840;
  localparam logic [TRIP_W-1:0]       TRIP_RST      = 8'd3;

  typedef enum logic [1:0] {
    ITEM_CHECK = 2'd0,
    ITEM_LATCH = 2'd1,
    ITEM_CLEAR = 2'd2
  } item_kind_t;

  typedef enum logic [2:0] {
    SENSE_FULL     = 3'd0,
    SENSE_DC       = 3'd1,
    SENSE_CURRENT  = 3'd2,
    SENSE_DC1      = 3'd3,
    SENSE_DC2      = 3'd4
  } sense_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UV_LIMIT  = 3'd0,
    REG_OV_LIMIT  = 3'd1,
    REG_IMB_LIMIT = 3'd2,
    REG_OC_LIMIT  = 3'd3,
    REG_TRIP      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [2:0]                      sensing_mode;
    logic                            sample_present;
    logic [SAMPLE_WIDTH-1:0]         dc1_volts;
    logic [SAMPLE_WIDTH-1:0]         dc2_volts;
    logic signed [SAMPLE_WIDTH-1:0]  current_amps;
    logic                            current_available;
    logic [FAULT_W-1:0]              latch_mask;
  } sample_t;

  typedef struct packed {
    logic [FAULT_W-1:0] tripped_faults;
    logic [FAULT_W-1:0] latched_faults;
  } result_t;

endpackage

### hw/rtl/debounced_bus_fault_protection.sv
// Top level: debounced bus fault detector with one-deep result skid.
//
//   channel  direction  handshake              payload
//   sample   in         sample_valid/ready     sample_t
//   result   out        result_valid/ready     result_t
//   cfg      in         cfg_valid/ready        cfg_index, cfg_data
//
// One sample beat per cycle while sample_ready is high; its result is
// registered. Checks, debounce counters and latch update sit between
// sample port and result register in one pass; counters and latch loop.
// A skid register holds one more result while result_ready is low, so
// sample_ready drops only when both are full. cfg_ready is always high.
// Reset (rst, synchronous) clears the state directly; no clearing pass.
`include "debounced_bus_fault_protection_assert.svh"

module debounced_bus_fault_protection import dbfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [VOLT_LIMIT_W-1:0]    uv_limit;
  logic [VOLT_LIMIT_W-1:0]    ov_limit;
  logic [VOLT_LIMIT_W-1:0]    imb_limit;
  logic [CUR_LIMIT_W-1:0]     oc_limit;
  logic [TRIP_W-1:0]          trip_count;

  logic [HIT_COUNT_WIDTH-1:0] hits      [HIT_BITS];
  logic [HIT_COUNT_WIDTH-1:0] hits_next [HIT_BITS];
  logic [FAULT_W-1:0]         latched;
  logic [FAULT_W-1:0]         latched_next;

  logic                       skid_valid;
  result_t                    skid;
  result_t                    res;

  logic                       sample_fire;
  logic                       result_fire;
  logic                       cfg_fire;

  logic [1:0]                 dc1_f;
  logic [1:0]                 dc2_f;
  logic                       oc_f;
  logic                       imb_f;
  logic [HIT_BITS-1:0]        inst;
  logic [FAULT_W-1:0]         tripped;
  logic [SAMPLE_WIDTH-1:0]    cur_mag;
  logic [SAMPLE_WIDTH-1:0]    dc_diff;

  assign sample_ready = !skid_valid;
  assign cfg_ready    = 1'b1;
  assign sample_fire  = sample_valid && sample_ready;
  assign result_fire  = result_valid && result_ready;
  assign cfg_fire     = cfg_valid && cfg_ready;

  function automatic logic [1:0] dc_fault(
    input logic [SAMPLE_WIDTH-1:0] volts,
    input logic [VOLT_LIMIT_W-1:0] lo,
    input logic [VOLT_LIMIT_W-1:0] hi
  );
    logic [1:0] f;
    f       = '0;
    f[0]    = VOLT_CMP_W'(volts) < VOLT_CMP_W'(lo);
    f[1]    = VOLT_CMP_W'(volts) > VOLT_CMP_W'(hi);
    return f;
  endfunction

  // instantaneous fault checks
  always_comb begin
    cur_mag = sample.current_amps[SAMPLE_WIDTH-1] ?
              (~sample.current_amps + 1'b1) : sample.current_amps;
    dc_diff = (sample.dc1_volts >= sample.dc2_volts) ?
              (sample.dc1_volts - sample.dc2_volts) :
              (sample.dc2_volts - sample.dc1_volts);
    dc1_f   = dc_fault(sample.dc1_volts, uv_limit, ov_limit);
    dc2_f   = dc_fault(sample.dc2_volts, uv_limit, ov_limit);
    oc_f    = CUR_CMP_W'(cur_mag) > CUR_CMP_W'(oc_limit);
    imb_f   = VOLT_CMP_W'(dc_diff) > VOLT_CMP_W'(imb_limit);
    inst    = '0;
    case (sample.sensing_mode)
      SENSE_FULL: begin
        inst = {imb_f, oc_f, dc1_f | dc2_f};
      end
      SENSE_DC: begin
        inst = {imb_f, 1'b0, dc1_f | dc2_f};
      end
      SENSE_CURRENT: begin
        inst = {1'b0, oc_f, 2'b00};
      end
      SENSE_DC1: begin
        inst = {1'b0, oc_f && sample.current_available, dc1_f};
      end
      SENSE_DC2: begin
        inst = {1'b0, oc_f && sample.current_available, dc2_f};
      end
      default: begin
        inst = '0;
      end
    endcase
  end

  // debounce counters and latch
  always_comb begin
    hits_next    = hits;
    latched_next = latched;
    tripped      = '0;
    case (sample.mode)
      ITEM_CHECK: begin
        if (!sample.sample_present) begin
          tripped[BIT_LOST] = 1'b1;
        end else begin
          for (int i = 0; i < HIT_BITS; i++) begin
            if (!inst[i]) begin
              hits_next[i] = '0;
            end else if (hits[i] != {HIT_COUNT_WIDTH{1'b1}}) begin
              hits_next[i] = hits[i] + 1'b1;
            end
            tripped[i] = inst[i] &&
                         (TRIP_CMP_W'(hits_next[i]) >= TRIP_CMP_W'(trip_count));
          end
        end
      end
      ITEM_LATCH: begin
        latched_next = latched | sample.latch_mask;
      end
      ITEM_CLEAR: begin
        latched_next = '0;
        for (int i = 0; i < HIT_BITS; i++) begin
          hits_next[i] = '0;
        end
      end
      default: begin
        latched_next = latched;
      end
    endcase
    res.tripped_faults = tripped;
    res.latched_faults = latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_limit   <= UV_LIMIT_RST;
      ov_limit   <= OV_LIMIT_RST;
      imb_limit  <= IMB_LIMIT_RST;
      oc_limit   <= OC_LIMIT_RST;
      trip_count <= TRIP_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_UV_LIMIT:  uv_limit   <= cfg_data[VOLT_LIMIT_W-1:0];
        REG_OV_LIMIT:  ov_limit   <= cfg_data[VOLT_LIMIT_W-1:0];
        REG_IMB_LIMIT: imb_limit  <= cfg_data[VOLT_LIMIT_W-1:0];
        REG_OC_LIMIT:  oc_limit   <= cfg_data[CUR_LIMIT_W-1:0];
        REG_TRIP:      trip_count <= cfg_data[TRIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched <= '0;
      for (int i = 0; i < HIT_BITS; i++) begin
        hits[i] <= '0;
      end
    end else if (sample_fire) begin
      latched <= latched_next;
      hits    <= hits_next;
    end
  end

  // result register plus one skid beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (sample_fire) begin
      if (!result_valid || result_fire) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_fire) begin
        result <= skid;
      end
    end else if (sample_fire) begin
      if (!result_valid || result_fire) begin
        result <= res;
      end else begin
        skid <= res;
      end
    end
  end

  `DBFP_ASSERT_SAME(a_skid_needs_result, clk, rst, skid_valid, result_valid)
  `DBFP_ASSERT_NEXT(a_clear_zeroes, clk, rst,
    sample_fire && (sample.mode == ITEM_CLEAR),
    (latched == '0) && (hits[BIT_UV] == '0) && (hits[BIT_IMB] == '0))
  `DBFP_ASSERT_NEXT(a_latch_holds_mask, clk, rst,
    sample_fire && (sample.mode == ITEM_LATCH),
    (latched & $past(sample.latch_mask)) == $past(sample.latch_mask))
  `DBFP_ASSERT_NEXT(a_lost_keeps_hits, clk, rst,
    sample_fire && (sample.mode == ITEM_CHECK) && !sample.sample_present,
    $stable(hits[BIT_OC]) && $stable(latched))

endmodule

### test/debounced_bus_fault_protection_tb.sv
// Testbench for the debounced bus fault protection block: directed table, random bursts.
module debounced_bus_fault_protection_tb;
  import dbfp_pkg::*;

  localparam logic [1:0]             ITEM_IGNORED = 2'd3;
  localparam logic [2:0]             SENSE_NONE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE    = 3'd5;
  localparam logic [FAULT_W-1:0]     NO_FAULTS    = '0;
  localparam logic [FAULT_W-1:0]     ALL_FAULTS   = '1;
  localparam logic [FAULT_W-1:0]     LOST_ONLY    = 5'b1 << BIT_LOST;
  localparam logic [HIT_COUNT_WIDTH-1:0] HIT_MAX  = '1;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    sample_t item;
    bit      has_exp;
    result_t exp;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_ready;
  sample_t                sample = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [VOLT_LIMIT_W-1:0]    uv_limit = UV_LIMIT_RST;
  logic [VOLT_LIMIT_W-1:0]    ov_limit = OV_LIMIT_RST;
  logic [VOLT_LIMIT_W-1:0]    imb_limit = IMB_LIMIT_RST;
  logic [CUR_LIMIT_W-1:0]     oc_limit = OC_LIMIT_RST;
  logic [TRIP_W-1:0]          trip_limit = TRIP_RST;
  logic [HIT_COUNT_WIDTH-1:0] hit_counts [4] = '{default: '0};
  logic [FAULT_W-1:0]         latched_bits = '0;

  result_t pending_results [$];
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;
  bit      hold_request = 1'b0;

  row_t directed_rows [25] = '{
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'd12000, 16'd12000, 16'sd0, 1'b1, 5'h00},
      1'b1, '{NO_FAULTS, NO_FAULTS}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b0, 16'd0, 16'hFFFF, 16'sh8000, 1'b1, 5'h1F},
      1'b1, '{LOST_ONLY, NO_FAULTS}},
    '{'{ITEM_LATCH, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h1F},
      1'b1, '{NO_FAULTS, ALL_FAULTS}},
    '{'{ITEM_IGNORED, SENSE_FULL, 1'b1, 16'd0, 16'hFFFF, 16'sh7FFF, 1'b1, 5'h00},
      1'b1, '{NO_FAULTS, ALL_FAULTS}},
    '{'{ITEM_CLEAR, SENSE_FULL, 1'b1, 16'hFFFF, 16'd0, 16'sh8000, 1'b1, 5'h1F},
      1'b1, '{NO_FAULTS, NO_FAULTS}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h00}, 1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h00}, 1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h00}, 1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'hFFFF, 16'hFFFF, 16'sh8000, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'hFFFF, 16'd0, 16'sh7FFF, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b0, 16'hFFFF, 16'd0, 16'sh7FFF, 1'b1, 5'h00},
      1'b1, '{LOST_ONLY, NO_FAULTS}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'hFFFF, 16'd0, 16'sh7FFF, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC, 1'b1, 16'd0, 16'hFFFF, 16'sh8000, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_CURRENT, 1'b1, 16'd12000, 16'd12000, 16'shF000, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC1, 1'b1, 16'hFFFF, 16'd0, 16'sh8000, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC1, 1'b1, 16'hFFFF, 16'd0, 16'sh8000, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC2, 1'b1, 16'd0, 16'hFFFF, 16'sh7FFF, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC2, 1'b1, 16'd0, 16'hFFFF, 16'sh7FFF, 1'b0, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_NONE, 1'b1, 16'd0, 16'hFFFF, 16'sh8000, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC1, 1'b1, 16'd10240, 16'd0, 16'sd3840, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_CHECK, SENSE_DC2, 1'b1, 16'd0, 16'd14848, 16'shF100, 1'b1, 5'h00},
      1'b0, '{0, 0}},
    '{'{ITEM_LATCH, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h0A}, 1'b0, '{0, 0}},
    '{'{ITEM_LATCH, SENSE_FULL, 1'b1, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h10}, 1'b0, '{0, 0}},
    '{'{ITEM_CLEAR, 3'd7, 1'b0, 16'd0, 16'd0, 16'sd0, 1'b0, 5'h00},
      1'b1, '{NO_FAULTS, NO_FAULTS}},
    '{'{ITEM_CHECK, SENSE_FULL, 1'b1, 16'd12000, 16'd11000, 16'sh0100, 1'b1, 5'h15},
      1'b1, '{NO_FAULTS, NO_FAULTS}}
  };

  debounced_bus_fault_protection u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [FAULT_W-1:0] volt_faults(logic [SAMPLE_WIDTH-1:0] v);
    logic [FAULT_W-1:0] f;
    f = '0;
    f[BIT_UV] = v < uv_limit;
    f[BIT_OV] = v > ov_limit;
    return f;
  endfunction

  function automatic logic [FAULT_W-1:0] current_faults(logic [SAMPLE_WIDTH-1:0] c);
    logic [SAMPLE_WIDTH:0] mag;
    logic [FAULT_W-1:0]    f;
    mag = c[SAMPLE_WIDTH-1] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
    f = '0;
    f[BIT_OC] = mag > {2'b00, oc_limit};
    return f;
  endfunction

  function automatic logic [FAULT_W-1:0] imbalance_faults(logic [SAMPLE_WIDTH-1:0] a,
                                                          logic [SAMPLE_WIDTH-1:0] b);
    logic [SAMPLE_WIDTH-1:0] d;
    logic [FAULT_W-1:0]      f;
    d = (a >= b) ? (a - b) : (b - a);
    f = '0;
    f[BIT_IMB] = d > imb_limit;
    return f;
  endfunction

  function automatic result_t predict_protection(sample_t s);
    logic [FAULT_W-1:0] inst;
    logic [FAULT_W-1:0] trip;
    logic [FAULT_W-1:0] cur;
    result_t            r;
    inst = '0;
    trip = '0;
    cur = current_faults(s.current_amps);
    case (s.mode)
      ITEM_CHECK: begin
        if (!s.sample_present) begin
          trip[BIT_LOST] = 1'b1;
        end else begin
          case (s.sensing_mode)
            SENSE_FULL: inst = volt_faults(s.dc1_volts) | volt_faults(s.dc2_volts) | cur
                               | imbalance_faults(s.dc1_volts, s.dc2_volts);
            SENSE_DC: inst = volt_faults(s.dc1_volts) | volt_faults(s.dc2_volts)
                             | imbalance_faults(s.dc1_volts, s.dc2_volts);
            SENSE_CURRENT: inst = cur;
            SENSE_DC1: inst = volt_faults(s.dc1_volts) | (s.current_available ? cur : '0);
            SENSE_DC2: inst = volt_faults(s.dc2_volts) | (s.current_available ? cur : '0);
            default: inst = '0;
          endcase
          for (int k = BIT_UV; k <= BIT_IMB; k++) begin
            if (!inst[k]) begin
              hit_counts[k] = '0;
            end else begin
              if (hit_counts[k] != HIT_MAX) hit_counts[k] = hit_counts[k] + 1'b1;
              trip[k] = hit_counts[k] >= trip_limit;
            end
          end
        end
      end
      ITEM_LATCH: latched_bits = latched_bits | s.latch_mask;
      ITEM_CLEAR: begin
        latched_bits = '0;
        for (int k = BIT_UV; k <= BIT_IMB; k++) hit_counts[k] = '0;
      end
      default: ;
    endcase
    r.tripped_faults = trip;
    r.latched_faults = latched_bits;
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pick_volts(logic [SAMPLE_WIDTH-1:0] near);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: v = int'(uv_limit) + int'($urandom_range(0, 4)) - 2;
      2: v = int'(ov_limit) + int'($urandom_range(0, 4)) - 2;
      3: v = $urandom_range(0, 1) ? 0 : 65535;
      4: v = int'(near) + ($urandom_range(0, 1) ? 1 : -1) * int'(imb_limit)
             + int'($urandom_range(0, 2)) - 1;
      default: v = (int'(uv_limit) + int'(ov_limit)) / 2 + int'($urandom_range(0, 64)) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic sample_t fresh_sample(logic [2:0] sense);
    sample_t s;
    int      c;
    s.mode = ITEM_CHECK;
    s.sensing_mode = sense;
    s.sample_present = 1'b1;
    s.dc1_volts = pick_volts(16'($urandom));
    s.dc2_volts = pick_volts(s.dc1_volts);
    case ($urandom_range(0, 4))
      0: c = int'($urandom_range(0, 65535)) - 32768;
      1: c = int'(oc_limit) + int'($urandom_range(0, 4)) - 2;
      2: c = -int'(oc_limit) + int'($urandom_range(0, 4)) - 2;
      3: c = $urandom_range(0, 1) ? -32768 : 32767;
      default: c = int'($urandom_range(0, 511)) - 256;
    endcase
    if (c < -32768) c = -32768;
    if (c > 32767) c = 32767;
    s.current_amps = c[SAMPLE_WIDTH-1:0];
    s.current_available = 1'($urandom_range(0, 1));
    s.latch_mask = 5'($urandom_range(0, 31));
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic offer_sample(sample_t s, bit typed, result_t typed_res);
    int      gap;
    result_t pred;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    pred = predict_protection(s);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_UV_LIMIT:  uv_limit = data;
      REG_OV_LIMIT:  ov_limit = data;
      REG_IMB_LIMIT: imb_limit = data;
      REG_OC_LIMIT:  oc_limit = data[CUR_LIMIT_W-1:0];
      REG_TRIP:      trip_limit = data[TRIP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_phase(logic [15:0] uv, logic [15:0] ov, logic [15:0] imb,
                           logic [15:0] oc, logic [15:0] trip, int n_items,
                           bit idle, bit squeeze, bit long_runs);
    int         left;
    int         len;
    int         noise;
    bit         steady;
    bit         long_burst;
    logic [2:0] sense;
    sample_t    base;
    sample_t    s;
    result_t    none;
    none = '0;
    while (pending_results.size() != 0) @(negedge clk);
    write_reg(REG_UV_LIMIT, uv);
    write_reg(REG_OV_LIMIT, ov);
    write_reg(REG_IMB_LIMIT, imb);
    write_reg(REG_OC_LIMIT, oc);
    write_reg(REG_TRIP, trip);
    write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
    cfg_valid <= 1'b0;
    idle_on = idle;
    hold_request = squeeze;
    left = n_items;
    while (left > 0) begin
      long_burst = long_runs ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
      if (long_burst) begin
        len = long_runs ? $urandom_range(256, 300) : $urandom_range(100, 300);
        sense = 3'($urandom_range(0, 4));
      end else begin
        len = $urandom_range(1, 30);
        sense = 3'($urandom_range(0, 7));
      end
      if (len > left) len = left;
      left -= len;
      steady = long_burst || ($urandom_range(0, 1) != 0);
      noise = steady ? 1 : 12;
      base = fresh_sample(sense);
      repeat (len) begin
        s = steady ? base : fresh_sample(sense);
        s.latch_mask = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < noise) begin
          case ($urandom_range(0, 4))
            0: s.sample_present = 1'b0;
            1: s.mode = ITEM_LATCH;
            2: s.mode = ITEM_CLEAR;
            3: s.mode = ITEM_IGNORED;
            default: s.sensing_mode = 3'($urandom_range(0, 7));
          endcase
        end
        offer_sample(s, 1'b0, none);
      end
    end
    sample_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int      gap;
    result_t want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.tripped_faults !== want.tripped_faults) begin
          $display("%0t: tripped_faults expected %h actual %h",
                   $time, want.tripped_faults, result.tripped_faults);
          mismatch_count++;
        end
        if (result.latched_faults !== want.latched_faults) begin
          $display("%0t: latched_faults expected %h actual %h",
                   $time, want.latched_faults, result.latched_faults);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int waited;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp);
    end
    sample_valid <= 1'b0;

    run_phase(UV_LIMIT_RST, OV_LIMIT_RST, IMB_LIMIT_RST, 16'(OC_LIMIT_RST), 16'd1,
              200, 1'b1, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFF00, 250, 1'b0, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'd255, 600, 1'b1, 1'b0, 1'b1);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd1, 200, 1'b1, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(1, 8)), 300, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom_range(8000, 12000)), 16'($urandom_range(12000, 16000)),
              16'($urandom_range(0, 4000)), 16'($urandom_range(0, 6000)),
              16'($urandom_range(1, 8)), 250, 1'b1, 1'b0, 1'b0);

    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
